// ===== rtl/core/lge_pkg.sv =====
// lge_pkg: shared opcodes, config register map and life rule constants
// for the life grid engine. No dependencies.
package lge_pkg;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_READ   = 2'd2,
    OP_STEP   = 2'd3
  } lge_op_e;

  // configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

  // smallest grid side that still wraps sensibly
  localparam int MIN_SIZE = 3;

  // life rule
  localparam logic [3:0] SURVIVE_LO = 4'd2;
  localparam logic [3:0] BIRTH_CNT  = 4'd3;

endpackage

// ===== rtl/core/lge_row_mem.sv =====
// lge_row_mem: row-wide grid storage, one write and one read port,
// registered read data. No package dependency.
module lge_row_mem #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lge_row_eval.sv =====
// lge_row_eval: next-generation value of one full row from the rows above,
// at and below, with toroidal column wrap. Depends on lge_pkg.
module lge_row_eval #(
  parameter int NCOLS = 64,
  parameter int CW    = 7
) (
  input  logic [NCOLS-1:0] up_i,
  input  logic [NCOLS-1:0] cur_i,
  input  logic [NCOLS-1:0] dn_i,
  input  logic [CW-1:0]    ncols_i,
  output logic [NCOLS-1:0] nxt_o
);
  import lge_pkg::*;

  localparam int AW = $clog2(NCOLS);

  logic [CW-1:0] last_col;
  logic [AW-1:0] last_idx;
  logic          up_last, cur_last, dn_last;

  // wrap-around source for column 0's left neighbors
  assign last_col = ncols_i - CW'(1);
  assign last_idx = last_col[AW-1:0];
  assign up_last  = up_i[last_idx];
  assign cur_last = cur_i[last_idx];
  assign dn_last  = dn_i[last_idx];

  for (genvar j = 0; j < NCOLS; j++) begin : g_lane
    logic       ul, cl, dl, ur, cr, dr;
    logic       wrap_r;
    logic [3:0] cnt;
    logic       rule;

    if (j == 0) begin : g_l0
      assign ul = up_last;
      assign cl = cur_last;
      assign dl = dn_last;
    end else begin : g_ln
      assign ul = up_i[j-1];
      assign cl = cur_i[j-1];
      assign dl = dn_i[j-1];
    end

    assign wrap_r = (CW'(j + 1) == ncols_i);
    if (j == NCOLS - 1) begin : g_rl
      assign ur = up_i[0];
      assign cr = cur_i[0];
      assign dr = dn_i[0];
    end else begin : g_rn
      assign ur = wrap_r ? up_i[0]  : up_i[j+1];
      assign cr = wrap_r ? cur_i[0] : cur_i[j+1];
      assign dr = wrap_r ? dn_i[0]  : dn_i[j+1];
    end

    assign cnt = 4'(ul) + 4'(up_i[j]) + 4'(ur) + 4'(cl) + 4'(cr)
               + 4'(dl) + 4'(dn_i[j]) + 4'(dr);
    assign rule = cur_i[j] ? ((cnt == SURVIVE_LO) || (cnt == BIRTH_CNT))
                           : (cnt == BIRTH_CNT);
    // columns outside the active area keep their value
    assign nxt_o[j] = (CW'(j) < ncols_i) ? rule : cur_i[j];
  end

endmodule

// ===== rtl/core/life_grid_engine_top.sv =====
// life_grid_engine_top: toroidal life grid with cell set/toggle/read and
// generation step. Depends on lge_pkg, lge_row_mem, lge_row_eval.
//
// Usage:
//   Requests enter on start/opcode_i/cell_col_i/cell_row_i/set_value_i and
//   are taken at a clock edge with start high and busy low. Each request
//   yields exactly one result on op_done_o/cell_alive_o, marked by done_o for
//   a single cycle; the receiver cannot stall it.
//   Set, toggle and read: one read-modify-write of the addressed row in the
//   row memory in the S_CELL state, registered onto done_o as it ends; busy is high for
//   1 cycle. Addresses outside the active area change nothing and read 0.
//   Generation step: rows are streamed through a three-row window
//   (above/current/below) plus a saved copy of old row 0; every active row
//   is evaluated and written back in place, one at a time through the single
//   row memory port pair. The request goes S_ST_UP, S_ST_FIRST (window fill),
//   then S_ST_ROW per active row (clamped) until done_o, busy high meanwhile.
//   Config (cfg_we_i/cfg_idx_i/cfg_data_i) is written at once, any time;
//   sizes are clamped to 3..MAX_COLS and 3..MAX_ROWS. Change it only idle.
//   Reset: sizes return to 64 (clamped) and a clearing pass writes every
//   row dead, one row per cycle, busy high meanwhile.
module life_grid_engine_top #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       opcode_i,
  input  logic [5:0]                       cell_col_i,
  input  logic [5:0]                       cell_row_i,
  input  logic                             set_value_i,
  // result channel
  output logic                             done_o,
  output logic [1:0]                       op_done_o,
  output logic                             cell_alive_o,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [lge_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lge_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import lge_pkg::*;

  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int ROW_AW = $clog2(MAX_ROWS);
  // size widths hold both the 7-bit register and the maximum
  localparam int COL_CW = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;
  localparam int ROW_CW = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
  localparam int COLS_RST = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int ROWS_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL,
    S_ST_UP,
    S_ST_FIRST,
    S_ST_ROW
  } state_e;

  function automatic logic [COL_CW-1:0] clamp_cols(logic [CFG_DATA_W-1:0] v);
    logic [COL_CW-1:0] ve;
    ve = COL_CW'(v);
    if (ve < COL_CW'(MIN_SIZE)) return COL_CW'(MIN_SIZE);
    if (ve > COL_CW'(MAX_COLS)) return COL_CW'(MAX_COLS);
    return ve;
  endfunction

  function automatic logic [ROW_CW-1:0] clamp_rows(logic [CFG_DATA_W-1:0] v);
    logic [ROW_CW-1:0] ve;
    ve = ROW_CW'(v);
    if (ve < ROW_CW'(MIN_SIZE)) return ROW_CW'(MIN_SIZE);
    if (ve > ROW_CW'(MAX_ROWS)) return ROW_CW'(MAX_ROWS);
    return ve;
  endfunction

  state_e            state_q;
  logic [COL_CW-1:0] cols_used_q;
  logic [ROW_CW-1:0] rows_used_q;
  logic [ROW_AW-1:0] r_q;           // clear row / step row
  lge_op_e           op_q;
  logic              inr_q;         // addressed cell inside active area
  logic              done_q;
  lge_op_e           op_done_q;
  logic              alive_q;

  // payload, no reset
  logic [5:0]          col_q;
  logic [ROW_AW-1:0]   row_q;
  logic                val_q;
  logic [MAX_COLS-1:0] up_q, cur_q, row0_q;

  logic                accept;
  lge_op_e             op_in;
  logic [ROW_CW-1:0]   row_in_ext;
  logic [ROW_CW-1:0]   rows_last;
  logic [ROW_CW-1:0]   r_plus2;
  logic                row_is_last;
  logic                clr_last;
  logic                in_range;

  logic                mem_we;
  logic [ROW_AW-1:0]   mem_waddr, mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata, mem_rdata;
  logic [MAX_COLS-1:0] dn_row, nxt_row, cell_wr;
  logic                old_bit, cell_bit;

  assign op_in       = lge_op_e'(opcode_i);
  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign row_in_ext  = ROW_CW'(cell_row_i);
  assign rows_last   = rows_used_q - ROW_CW'(1);
  assign r_plus2     = ROW_CW'(r_q) + ROW_CW'(2);
  assign row_is_last = (ROW_CW'(r_q) == rows_last);
  assign clr_last    = (r_q == ROW_AW'(MAX_ROWS - 1));
  assign in_range    = (COL_CW'(cell_col_i) < cols_used_q) && (row_in_ext < rows_used_q);

  // config registers hold the clamped size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_used_q <= COL_CW'(COLS_RST);
      rows_used_q <= ROW_CW'(ROWS_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLS: cols_used_q <= clamp_cols(cfg_data_i);
        CFG_ROWS: rows_used_q <= clamp_rows(cfg_data_i);
        default:  ;
      endcase
    end
  end

  // cell read-modify-write: pick the old bit and patch the row
  always_comb begin
    old_bit = 1'b0;
    for (int j = 0; j < MAX_COLS; j++) begin
      if (COL_CW'(col_q) == COL_CW'(j)) old_bit = mem_rdata[j];
    end
    case (op_q)
      OP_SET:    cell_bit = val_q;
      OP_TOGGLE: cell_bit = ~old_bit;
      default:   cell_bit = old_bit;
    endcase
    for (int j = 0; j < MAX_COLS; j++) begin
      cell_wr[j] = (COL_CW'(col_q) == COL_CW'(j)) ? cell_bit : mem_rdata[j];
    end
  end

  // last row's lower neighbor is the saved old row 0
  assign dn_row = row_is_last ? row0_q : mem_rdata;

  lge_row_eval #(
    .NCOLS (MAX_COLS),
    .CW    (COL_CW)
  ) u_eval (
    .up_i    (up_q),
    .cur_i   (cur_q),
    .dn_i    (dn_row),
    .ncols_i (cols_used_q),
    .nxt_o   (nxt_row)
  );

  // memory port steering
  always_comb begin
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = r_q;
    mem_wdata = nxt_row;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_IDLE: begin
        mem_raddr = (op_in == OP_STEP) ? rows_last[ROW_AW-1:0] : row_in_ext[ROW_AW-1:0];
      end
      S_CELL: begin
        mem_we    = inr_q && (op_q != OP_READ);
        mem_waddr = row_q;
        mem_wdata = cell_wr;
      end
      S_ST_UP:    mem_raddr = '0;
      S_ST_FIRST: mem_raddr = ROW_AW'(1);
      S_ST_ROW: begin
        // rows ahead of the write pointer are still old
        mem_raddr = r_plus2[ROW_AW-1:0];
        mem_we    = 1'b1;
      end
      default: ;
    endcase
  end

  lge_row_mem #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      r_q       <= '0;
      op_q      <= OP_SET;
      inr_q     <= 1'b0;
      done_q    <= 1'b0;
      op_done_q <= OP_SET;
      alive_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          r_q <= r_q + ROW_AW'(1);
          if (clr_last) begin
            r_q     <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q    <= op_in;
            inr_q   <= in_range;
            state_q <= (op_in == OP_STEP) ? S_ST_UP : S_CELL;
          end
        end
        S_CELL: begin
          done_q    <= 1'b1;
          op_done_q <= op_q;
          alive_q   <= inr_q & cell_bit;
          state_q   <= S_IDLE;
        end
        S_ST_UP: state_q <= S_ST_FIRST;
        S_ST_FIRST: begin
          r_q     <= '0;
          state_q <= S_ST_ROW;
        end
        S_ST_ROW: begin
          r_q <= r_q + ROW_AW'(1);
          if (row_is_last) begin
            r_q       <= '0;
            done_q    <= 1'b1;
            op_done_q <= OP_STEP;
            alive_q   <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers: request fields and the row window
  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= cell_col_i;
      row_q <= row_in_ext[ROW_AW-1:0];
      val_q <= set_value_i;
    end
    case (state_q)
      S_ST_UP: up_q <= mem_rdata;
      S_ST_FIRST: begin
        cur_q  <= mem_rdata;
        row0_q <= mem_rdata;
      end
      S_ST_ROW: begin
        up_q  <= cur_q;
        cur_q <= dn_row;
      end
      default: ;
    endcase
  end

  assign done_o       = done_q;
  assign op_done_o    = op_done_q;
  assign cell_alive_o = alive_q;

endmodule
